>>> rtl/core/che_pkg.sv
// Shared types and constants for the hit energy accumulation table.
// Request, result and cell-to-cell token structs; no dependencies.
`timescale 1ns / 1ps

package che_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;
  localparam int RIDX_W        = 8;
  localparam int CMP_W         = (IDX_W > RIDX_W) ? IDX_W : RIDX_W;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [7:0]         det_id;
    logic [7:0]         col_id;
    logic [7:0]         row_id;
    logic signed [31:0] particle_code;
    logic [31:0]        energy_in;
    logic [7:0]         read_index;
  } req_t;

  typedef struct packed {
    logic [7:0]         entry_index;
    logic               hit_merged;
    logic               hit_dropped;
    logic [31:0]        energy_sum;
    logic [7:0]         entry_det;
    logic [7:0]         entry_col;
    logic [7:0]         entry_row;
    logic signed [31:0] entry_particle;
    logic               entry_valid;
    logic [8:0]         entries_used;
  } rsp_t;

  // request walking down the row of cells, with its outcome once resolved
  typedef struct packed {
    logic               active;
    logic               is_read;
    logic [7:0]         det;
    logic [7:0]         col;
    logic [7:0]         row;
    logic signed [31:0] pid;
    logic [31:0]        energy;
    logic [RIDX_W-1:0]  ridx;
    logic               resolved;
    logic               merged;
    logic [IDX_W-1:0]   idx;
    logic [31:0]        sum;
  } tok_t;

endpackage

>>> rtl/core/che_cell.sv
// One table entry: stored keys and energy, compare and update logic.
// Passes the walking request token to the next cell every cycle. Uses che_pkg.
`timescale 1ns / 1ps

module che_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [che_pkg::IDX_W-1:0] idx,
  input  logic [che_pkg::CNT_W-1:0] count,
  input  che_pkg::tok_t             tok_in,
  output che_pkg::tok_t             tok_out
);
  import che_pkg::*;

  logic [7:0]         key_det;
  logic [7:0]         key_col;
  logic [7:0]         key_row;
  logic signed [31:0] key_pid;
  logic [31:0]        energy;

  logic        occupied;
  logic        key_hit;
  logic        pending;
  logic        do_merge;
  logic        do_append;
  logic        do_read;
  logic [32:0] acc;
  logic [31:0] sat;
  tok_t        tok_next;

  always_comb begin
    occupied  = {1'b0, idx} < count;
    key_hit   = occupied && (key_det == tok_in.det) && (key_col == tok_in.col) &&
                (key_row == tok_in.row) && (key_pid == tok_in.pid);
    acc       = {1'b0, energy} + {1'b0, tok_in.energy};
    sat       = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
    pending   = tok_in.active && !tok_in.resolved;
    do_merge  = pending && !tok_in.is_read && key_hit;
    do_append = pending && !tok_in.is_read && ({1'b0, idx} == count);
    do_read   = pending && tok_in.is_read && occupied &&
                (CMP_W'(tok_in.ridx) == CMP_W'(idx));

    tok_next = tok_in;
    if (do_merge) begin
      tok_next.resolved = 1'b1;
      tok_next.merged   = 1'b1;
      tok_next.idx      = idx;
      tok_next.sum      = sat;
    end else if (do_append) begin
      tok_next.resolved = 1'b1;
      tok_next.idx      = idx;
      tok_next.sum      = tok_in.energy;
    end else if (do_read) begin
      tok_next.resolved = 1'b1;
      tok_next.idx      = idx;
      tok_next.sum      = energy;
      tok_next.det      = key_det;
      tok_next.col      = key_col;
      tok_next.row      = key_row;
      tok_next.pid      = key_pid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_merge) begin
      energy <= sat;
    end else if (do_append) begin
      key_det <= tok_in.det;
      key_col <= tok_in.col;
      key_row <= tok_in.row;
      key_pid <= tok_in.pid;
      energy  <= tok_in.energy;
    end
  end

endmodule

>>> rtl/core/cell_hit_energy_accumulator_top.sv
// Top level of the hit energy accumulation table: command FSM, entry count,
// result register and the row of che_cell entries. Uses che_pkg and che_cell.
`timescale 1ns / 1ps

// An add or read request is taken when start is high and busy is low, is
// registered into inj, then walks the row of TABLE_ENTRIES cells one cell
// per clock; its result is registered into rsp after the last cell. Busy is
// high while it walks and drops in the cycle the result shows, so add and
// read requests cannot overlap. The walk length is set by the row of cells,
// each of which compares and updates its own entry as the request passes.
// Clear and command three leave busy low; their result shows the cycle after
// acceptance. Each result is on rsp for exactly one cycle with done high;
// the receiver cannot stall it, so it must capture rsp whenever done is high.
module cell_hit_energy_accumulator_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  che_pkg::req_t req,
  output logic          done,
  output che_pkg::rsp_t rsp
);
  import che_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  tok_t             inj;
  tok_t             inj_next;
  rsp_t             rsp_next;
  logic             done_next;
  logic             accept;
  logic             appended;
  tok_t             link [TABLE_ENTRIES+1];
  tok_t             tail;

  assign busy    = (state == S_WALK);
  assign accept  = start && !busy;
  assign link[0] = inj;
  assign tail    = link[TABLE_ENTRIES];

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    che_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (IDX_W'(i)),
      .count   (count),
      .tok_in  (link[i]),
      .tok_out (link[i+1])
    );
  end

  always_comb begin
    state_next = state;
    count_next = count;
    inj_next   = '0;
    rsp_next   = '0;
    done_next  = 1'b0;
    appended   = tail.resolved && !tail.is_read && !tail.merged;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req.cmd) inside
            CMD_ADD, CMD_READ: begin
              inj_next.active  = 1'b1;
              inj_next.is_read = (req.cmd == CMD_READ);
              inj_next.det     = req.det_id;
              inj_next.col     = req.col_id;
              inj_next.row     = req.row_id;
              inj_next.pid     = req.particle_code;
              inj_next.energy  = req.energy_in;
              inj_next.ridx    = req.read_index;
              state_next       = S_WALK;
            end
            CMD_CLEAR, CMD_NOP: begin
              if (req.cmd == CMD_CLEAR) begin
                count_next = '0;
              end
              done_next             = 1'b1;
              rsp_next.entries_used = 9'(count_next);
            end
          endcase
        end
      end
      S_WALK: begin
        if (tail.active) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
          if (tail.resolved) begin
            rsp_next.entry_index    = 8'(tail.idx);
            rsp_next.hit_merged     = tail.merged;
            rsp_next.energy_sum     = tail.sum;
            rsp_next.entry_det      = tail.det;
            rsp_next.entry_col      = tail.col;
            rsp_next.entry_row      = tail.row;
            rsp_next.entry_particle = tail.pid;
            rsp_next.entry_valid    = 1'b1;
            if (appended) begin
              count_next = count + 1'b1;
            end
          end else begin
            rsp_next.hit_dropped = !tail.is_read;
          end
          rsp_next.entries_used = 9'(count_next);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
    if (rst) begin
      inj.active <= 1'b0;
    end else begin
      inj <= inj_next;
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(rsp.hit_merged && rsp.hit_dropped))
    else $error("merged and dropped both set");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count beyond table size");

  a_tail_in_walk: assert property (@(posedge clk) disable iff (rst)
    tail.active |-> (state == S_WALK))
    else $error("request left the cell row outside a walk");

  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.cmd == CMD_ADD || req.cmd == CMD_READ)) |=> busy)
    else $error("add or read accepted without going busy");

endmodule
